>>> sv/affine_2d_point_transform_core_macros.svh
// Assertion macros shared by the transform core modules.
`ifndef AFFINE_2D_POINT_TRANSFORM_CORE_MACROS_SVH
`define AFFINE_2D_POINT_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define A2T_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define A2T_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/a2t_pkg.sv
// Shared constants, types and the CORDIC arctangent table of the transform core.
`default_nettype none
package a2t_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int FRAC_BITS    = 16;
  localparam int TRIG_WIDTH   = 18;
  localparam int TRIG_ONE_I   = 1 << FRAC_BITS;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH;

  // CORDIC sizing
  localparam int PHASE_W      = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_XY_W  = CORDIC_FRAC + 4;
  localparam int CORDIC_Z_W   = PHASE_W + 1;
  localparam int CORDIC_X0    = 652032874;

  // Datapath widths
  localparam int PROD_W       = 2 * COORD_WIDTH;
  localparam int ROT_W        = PROD_W + TRIG_WIDTH;
  localparam int SUM_W        = ROT_W + 1;
  localparam int RND_SHIFT    = 2 * FRAC_BITS;
  localparam int RND_W        = SUM_W - RND_SHIFT;
  localparam int FIN_W        = RND_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE    = 3'd0,
    REG_SCALE_X  = 3'd1,
    REG_SCALE_Y  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] scale_x;
    logic signed [COORD_WIDTH-1:0] scale_y;
    logic signed [COORD_WIDTH-1:0] offset_x;
    logic signed [COORD_WIDTH-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic                         busy;
    logic signed [TRIG_WIDTH-1:0] cos_val;
    logic signed [TRIG_WIDTH-1:0] sin_val;
  } trig_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_Z_W-1:0] cordic_atan(
    input logic [CORDIC_CNT_W-1:0] idx
  );
    logic signed [CORDIC_Z_W-1:0] val;
    case (idx)
      5'd0:    val = CORDIC_Z_W'(536870912);
      5'd1:    val = CORDIC_Z_W'(316933406);
      5'd2:    val = CORDIC_Z_W'(167458907);
      5'd3:    val = CORDIC_Z_W'(85004757);
      5'd4:    val = CORDIC_Z_W'(42667331);
      5'd5:    val = CORDIC_Z_W'(21354465);
      5'd6:    val = CORDIC_Z_W'(10679838);
      5'd7:    val = CORDIC_Z_W'(5340245);
      5'd8:    val = CORDIC_Z_W'(2670163);
      5'd9:    val = CORDIC_Z_W'(1335087);
      5'd10:   val = CORDIC_Z_W'(667544);
      5'd11:   val = CORDIC_Z_W'(333772);
      5'd12:   val = CORDIC_Z_W'(166886);
      5'd13:   val = CORDIC_Z_W'(83443);
      5'd14:   val = CORDIC_Z_W'(41722);
      5'd15:   val = CORDIC_Z_W'(20861);
      5'd16:   val = CORDIC_Z_W'(10430);
      5'd17:   val = CORDIC_Z_W'(5215);
      5'd18:   val = CORDIC_Z_W'(2608);
      5'd19:   val = CORDIC_Z_W'(1304);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

>>> sv/a2t_in_if.sv
// Input point channel: valid/ready handshake with command and coordinates.
`default_nettype none
interface a2t_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [a2t_pkg::COORD_WIDTH-1:0] in_x;
  logic signed [a2t_pkg::COORD_WIDTH-1:0] in_y;

  modport source (output valid, cmd, in_x, in_y, input ready);
  modport sink   (input valid, cmd, in_x, in_y, output ready);
endinterface
`default_nettype wire

>>> sv/a2t_out_if.sv
// Result channel: valid/ready handshake with transformed coordinates and clip flag.
`default_nettype none
interface a2t_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [a2t_pkg::COORD_WIDTH-1:0] out_x;
  logic signed [a2t_pkg::COORD_WIDTH-1:0] out_y;
  logic                                   saturated;

  modport source (output valid, out_x, out_y, saturated, input ready);
  modport sink   (input valid, out_x, out_y, saturated, output ready);
endinterface
`default_nettype wire

>>> sv/affine_2d_point_transform_core.sv
// Top level of the 2D scale, rotate and translate core: registers, CORDIC and pipeline.
//
//   channel   dir   handshake            payload
//   in_i      in    valid/ready          cmd, in_x, in_y (Q16.16)
//   out_o     out   valid/ready          out_x, out_y (Q16.16), saturated
//   cfg       in    cfg_we_i, no ready   cfg_idx_i, cfg_data_i
//
// One point per cycle while out_o is not stalled and the CORDIC is idle; a result is
// registered through scale multiply, rotation multiply, round, translate and saturate.
// An angle write runs the shared CORDIC (20 iterations and a rounding step) with
// in_i.ready low; an angle on an exact quarter turn needs no iterations.
// A stall on out_o freezes the whole pipe in place; in_i.ready follows it.
// Reset is asynchronous, active low, and gives unit scale, zero offset, zero angle.
`default_nettype none
module affine_2d_point_transform_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [a2t_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [a2t_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  a2t_in_if.sink                                 in_i,
  a2t_out_if.source                              out_o
);

  localparam int CW = a2t_pkg::COORD_WIDTH;

  a2t_pkg::cfg_t  cfg_q;
  a2t_pkg::trig_t trig;
  logic           angle_wr;

  // Angle writes go straight to the CORDIC; it keeps the result, not the angle
  assign angle_wr = cfg_we_i && (cfg_idx_i == a2t_pkg::REG_ANGLE);

  // Scale and offset registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_x  <= CW'(a2t_pkg::TRIG_ONE_I);
      cfg_q.scale_y  <= CW'(a2t_pkg::TRIG_ONE_I);
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        a2t_pkg::REG_SCALE_X:  cfg_q.scale_x  <= cfg_data_i[CW-1:0];
        a2t_pkg::REG_SCALE_Y:  cfg_q.scale_y  <= cfg_data_i[CW-1:0];
        a2t_pkg::REG_OFFSET_X: cfg_q.offset_x <= cfg_data_i[CW-1:0];
        a2t_pkg::REG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i[CW-1:0];
        default: begin
          // angle is handled by the CORDIC; other indexes do nothing
        end
      endcase
    end
  end

  // Sine/cosine generator, rerun on each angle write
  a2t_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (angle_wr),
    .angle_i (cfg_data_i[a2t_pkg::ANGLE_WIDTH-1:0]),
    .trig_o  (trig)
  );

  // Point pipeline; holds off new transfers while the CORDIC is busy
  a2t_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .trig_i (trig),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

>>> sv/a2t_trig.sv
// Iterative CORDIC that turns a binary angle into Q1.16 cosine and sine.
`default_nettype none
module a2t_trig (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [a2t_pkg::ANGLE_WIDTH-1:0]  angle_i,
  output a2t_pkg::trig_t                        trig_o
);

  `include "affine_2d_point_transform_core_macros.svh"

  localparam int XY_W  = a2t_pkg::CORDIC_XY_W;
  localparam int Z_W   = a2t_pkg::CORDIC_Z_W;
  localparam int T_W   = a2t_pkg::TRIG_WIDTH;
  localparam int PH_W  = a2t_pkg::PHASE_W;
  localparam int CNT_W = a2t_pkg::CORDIC_CNT_W;
  localparam int OUT_SHIFT = a2t_pkg::CORDIC_FRAC - a2t_pkg::FRAC_BITS;

  localparam logic signed [XY_W-1:0] XY_ONE  = XY_W'(a2t_pkg::TRIG_ONE_I);
  localparam logic signed [XY_W-1:0] XY_MONE = -XY_W'(a2t_pkg::TRIG_ONE_I);
  localparam logic signed [XY_W-1:0] XY_RND  = XY_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [T_W-1:0]  T_ONE   = T_W'(a2t_pkg::TRIG_ONE_I);
  localparam logic signed [T_W-1:0]  T_MONE  = -T_W'(a2t_pkg::TRIG_ONE_I);
  localparam logic [CNT_W-1:0]       LAST_STEP = CNT_W'(a2t_pkg::CORDIC_STEPS - 1);
  localparam logic [PH_W-1:0]        HALF_QUARTER = PH_W'(1) << (PH_W - 3);

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_ITER,
    TRIG_DONE
  } trig_state_e;

  trig_state_e                state_q;
  logic [CNT_W-1:0]           step_q;
  logic signed [XY_W-1:0]     x_q, y_q;
  logic signed [Z_W-1:0]      z_q;
  logic [1:0]                 quad_q;
  logic signed [T_W-1:0]      cos_q, sin_q;

  logic [PH_W-1:0]            phase, phase_rnd, resid;
  logic [1:0]                 quad_now;
  logic signed [Z_W-1:0]      z_start;
  logic signed [XY_W-1:0]     dx, dy;
  logic signed [Z_W-1:0]      atan_val;
  logic signed [XY_W-1:0]     x_nx, y_nx;
  logic signed [Z_W-1:0]      z_nx;
  logic signed [XY_W-1:0]     c_full, s_full, c_clip, s_clip;
  logic signed [T_W-1:0]      c_sel, s_sel, cos_d, sin_d;
  logic [1:0]                 quad_sel;

  // Split the phase into the nearest quarter turn and a residual in [-1/8, 1/8) turn
  always_comb begin
    phase     = {angle_i, {(PH_W - a2t_pkg::ANGLE_WIDTH){1'b0}}};
    phase_rnd = phase + HALF_QUARTER;
    quad_now  = phase_rnd[PH_W-1 -: 2];
    resid     = phase - {quad_now, {(PH_W - 2){1'b0}}};
    z_start   = Z_W'(signed'(resid));
  end

  // One micro-rotation per cycle
  always_comb begin
    dx       = y_q >>> step_q;
    dy       = x_q >>> step_q;
    atan_val = a2t_pkg::cordic_atan(step_q);
    if (!z_q[Z_W-1]) begin
      x_nx = x_q - dx;
      y_nx = y_q + dy;
      z_nx = z_q - atan_val;
    end else begin
      x_nx = x_q + dx;
      y_nx = y_q - dy;
      z_nx = z_q + atan_val;
    end
  end

  // Round to 16 fraction bits, clamp to +-1.0, then fold in the quarter turn
  always_comb begin
    c_full = (x_q + XY_RND) >>> OUT_SHIFT;
    s_full = (y_q + XY_RND) >>> OUT_SHIFT;
    c_clip = (c_full > XY_ONE) ? XY_ONE : ((c_full < XY_MONE) ? XY_MONE : c_full);
    s_clip = (s_full > XY_ONE) ? XY_ONE : ((s_full < XY_MONE) ? XY_MONE : s_full);
    if (state_q == TRIG_DONE && !start_i) begin
      c_sel    = T_W'(c_clip);
      s_sel    = T_W'(s_clip);
      quad_sel = quad_q;
    end else begin
      c_sel    = T_ONE;
      s_sel    = '0;
      quad_sel = quad_now;
    end
    case (quad_sel)
      2'd0:    begin cos_d = c_sel;  sin_d = s_sel;  end
      2'd1:    begin cos_d = -s_sel; sin_d = c_sel;  end
      2'd2:    begin cos_d = -c_sel; sin_d = -s_sel; end
      default: begin cos_d = s_sel;  sin_d = -c_sel; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      step_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      quad_q  <= '0;
      cos_q   <= T_ONE;
      sin_q   <= '0;
    end else if (start_i) begin
      // a new angle always wins, even over a run in progress
      if (resid == '0) begin
        // exact quarter turn: no iterations needed
        state_q <= TRIG_IDLE;
        cos_q   <= cos_d;
        sin_q   <= sin_d;
      end else begin
        state_q <= TRIG_ITER;
        step_q  <= '0;
        x_q     <= XY_W'(a2t_pkg::CORDIC_X0);
        y_q     <= '0;
        z_q     <= z_start;
        quad_q  <= quad_now;
      end
    end else begin
      case (state_q)
        TRIG_IDLE: begin
          // hold the last result until the next angle write
        end
        TRIG_ITER: begin
          x_q    <= x_nx;
          y_q    <= y_nx;
          z_q    <= z_nx;
          step_q <= step_q + CNT_W'(1);
          if (step_q == LAST_STEP) begin
            state_q <= TRIG_DONE;
          end
        end
        TRIG_DONE: begin
          cos_q   <= cos_d;
          sin_q   <= sin_d;
          state_q <= TRIG_IDLE;
        end
        default: begin
          state_q <= TRIG_IDLE;
        end
      endcase
    end
  end

  assign trig_o.busy    = (state_q != TRIG_IDLE);
  assign trig_o.cos_val = cos_q;
  assign trig_o.sin_val = sin_q;

  `A2T_ASSERT_IMPL(a_step_range, state_q == TRIG_ITER, step_q <= LAST_STEP, "CORDIC step overrun")
  `A2T_ASSERT_NEXT(a_last_step, state_q == TRIG_ITER && step_q == LAST_STEP && !start_i, state_q == TRIG_DONE, "CORDIC did not finish after last step")
  `A2T_ASSERT_NEXT(a_done_once, state_q == TRIG_DONE && !start_i, state_q == TRIG_IDLE, "CORDIC result stage held")
  `A2T_ASSERT_IMPL(a_trig_range, state_q == TRIG_IDLE, cos_q <= T_ONE && cos_q >= T_MONE && sin_q <= T_ONE && sin_q >= T_MONE, "sine or cosine outside unit range")

endmodule
`default_nettype wire

>>> sv/a2t_datapath.sv
// Four-stage scale, rotate, round, translate and saturate pipeline.
`default_nettype none
module a2t_datapath (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire a2t_pkg::cfg_t  cfg_i,
  input  wire a2t_pkg::trig_t trig_i,
  a2t_in_if.sink     in_i,
  a2t_out_if.source  out_o
);

  `include "affine_2d_point_transform_core_macros.svh"

  localparam int CW  = a2t_pkg::COORD_WIDTH;
  localparam int PW  = a2t_pkg::PROD_W;
  localparam int RW  = a2t_pkg::ROT_W;
  localparam int SW  = a2t_pkg::SUM_W;
  localparam int NW  = a2t_pkg::RND_W;
  localparam int FW  = a2t_pkg::FIN_W;
  localparam int SH  = a2t_pkg::RND_SHIFT;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (SH - 1);
  localparam logic signed [CW-1:0] SAT_MAX  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN  = {1'b1, {(CW - 1){1'b0}}};

  logic adv, in_fire, out_fire;

  logic v1_q, v2_q, v3_q, v4_q;
  logic cmd1_q, cmd2_q, cmd3_q;
  logic signed [PW-1:0] sx1_q, sy1_q;
  logic signed [RW-1:0] pxc2_q, pys2_q, pxs2_q, pyc2_q;
  logic signed [NW-1:0] rx3_q, ry3_q;
  logic signed [CW-1:0] out_x_q, out_y_q;
  logic                 sat_q;

  logic signed [SW-1:0] rx_sum, ry_sum;
  logic signed [FW-1:0] fx, fy;
  logic signed [CW-1:0] out_x_d, out_y_d;
  logic                 clip_x, clip_y;
  logic [3:0]           occ;

  // whole pipe advances together; the output register is the last stage
  assign adv      = !v4_q || out_o.ready;
  assign in_i.ready = adv && !trig_i.busy;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    rx_sum = SW'(pxc2_q) - SW'(pys2_q) + RND_HALF;
    ry_sum = SW'(pxs2_q) + SW'(pyc2_q) + RND_HALF;
  end

  always_comb begin
    fx = FW'(rx3_q) + (cmd3_q ? FW'(0) : FW'(cfg_i.offset_x));
    fy = FW'(ry3_q) + (cmd3_q ? FW'(0) : FW'(cfg_i.offset_y));
    clip_x = (fx[FW-1:CW-1] != {(FW - CW + 1){fx[FW-1]}});
    clip_y = (fy[FW-1:CW-1] != {(FW - CW + 1){fy[FW-1]}});
    out_x_d = clip_x ? (fx[FW-1] ? SAT_MIN : SAT_MAX) : CW'(fx);
    out_y_d = clip_y ? (fy[FW-1] ? SAT_MIN : SAT_MAX) : CW'(fy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: per-axis scale, exact 32 fraction bits
      cmd1_q  <= in_i.cmd;
      sx1_q   <= PW'(cfg_i.scale_x) * PW'(in_i.in_x);
      sy1_q   <= PW'(cfg_i.scale_y) * PW'(in_i.in_y);
      // stage 2: rotation products, 48 fraction bits
      cmd2_q  <= cmd1_q;
      pxc2_q  <= RW'(sx1_q) * RW'(trig_i.cos_val);
      pys2_q  <= RW'(sy1_q) * RW'(trig_i.sin_val);
      pxs2_q  <= RW'(sx1_q) * RW'(trig_i.sin_val);
      pyc2_q  <= RW'(sy1_q) * RW'(trig_i.cos_val);
      // stage 3: sum and round half up to 16 fraction bits
      cmd3_q  <= cmd2_q;
      rx3_q   <= rx_sum[SW-1:SH];
      ry3_q   <= ry_sum[SW-1:SH];
      // stage 4: translate and saturate
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      sat_q   <= clip_x || clip_y;
    end
  end

  assign out_o.valid     = v4_q;
  assign out_o.out_x     = out_x_q;
  assign out_o.out_y     = out_y_q;
  assign out_o.saturated = sat_q;

  assign occ = {v1_q, v2_q, v3_q, v4_q};

  `A2T_ASSERT_NEXT(a_occ_hold, !in_fire && !out_fire, $countones(occ) == $countones($past(occ)), "item lost or invented in pipeline")
  `A2T_ASSERT_NEXT(a_occ_grow, in_fire && !out_fire, $countones(occ) == $countones($past(occ)) + 1, "accepted item not tracked")
  `A2T_ASSERT_IMPL(a_busy_block, trig_i.busy, !in_i.ready, "item accepted during sine and cosine update")
  `A2T_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, $stable(out_x_q) && $stable(out_y_q) && $stable(sat_q), "stalled result changed")

endmodule
`default_nettype wire
